/* hdl/rdb_pkg.sv */
// shared types, codes and defaults for the reversible deque buffer
`timescale 1ns / 1ps

package rdb_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int FILL_W    = 11;

    // item modes
    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_TAKE   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       side;
        logic [7:0] char_in;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        char_out;
        logic              last;
        logic [FILL_W-1:0] fill;
    } t_out_word;

    // memory operation handed from front to back, address travels beside it
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [7:0]        data;
        logic [1:0]        status;
        logic              last;
        logic [FILL_W-1:0] fill;
    } t_op;

endpackage

/* hdl/rdb_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps

module rdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rdb_front.sv */
// front end: pointer state, item classification and memory op build
`timescale 1ns / 1ps

module rdb_front import rdb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_in_word                 i_word,
    output logic                     o_push,
    output t_op                      o_op,
    output logic [$clog2(DEPTH)-1:0] o_addr
);

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_flag, n_flag;

    logic [CW-1:0]        w_k;
    logic [AW1-1:0]       w_sum;
    logic [AW1-1:0]       w_wrap;
    logic [AW-1:0]        w_slot;
    logic [AW-1:0]        w_head_dec;
    logic [CW+FILL_W-1:0] w_fill_wide;
    t_op                  w_op;
    logic [AW-1:0]        w_addr;

    // ring slot at offset k past head
    always_comb begin
        if (i_word.mode == MODE_ADD) begin
            w_k = r_count;
        end else if (r_flag) begin
            w_k = r_count - 1'b1;
        end else begin
            w_k = CW'(1);
        end
        w_sum  = AW1'(r_head) + AW1'(w_k);
        w_wrap = (w_sum >= AW1'(DEPTH)) ? w_sum - AW1'(DEPTH) : w_sum;
        w_slot = w_wrap[AW-1:0];
    end

    assign w_head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_fill_wide = {{FILL_W{1'b0}}, n_count};

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_flag      = r_flag;
        w_addr      = r_head;
        w_op.wr     = 1'b0;
        w_op.rd     = 1'b0;
        w_op.data   = i_word.char_in;
        w_op.status = ST_OK;
        w_op.last   = 1'b0;
        unique case (i_word.mode)
            MODE_TOGGLE: begin
                n_flag = ~r_flag;
            end
            MODE_ADD: begin
                if (r_count == CW'(DEPTH)) begin
                    w_op.status = ST_FULL;
                end else begin
                    w_op.wr = 1'b1;
                    n_count = r_count + 1'b1;
                    if ((i_word.side ^ r_flag) == 1'b0) begin
                        n_head = w_head_dec;
                        w_addr = w_head_dec;
                    end else begin
                        w_addr = w_slot;
                    end
                end
            end
            MODE_TAKE: begin
                if (r_count == '0) begin
                    w_op.status = ST_EMPTY;
                end else begin
                    w_op.rd   = 1'b1;
                    n_count   = r_count - 1'b1;
                    w_op.last = (r_count == CW'(1));
                    if (r_flag) begin
                        w_addr = w_slot;
                    end else begin
                        w_addr = r_head;
                        n_head = w_slot;
                    end
                end
            end
            default: begin
            end
        endcase
        w_op.fill = w_fill_wide[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    assign o_push = i_accept;
    assign o_op   = w_op;
    assign o_addr = w_addr;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW1'(r_head) < AW1'(DEPTH))
        else $error("head index outside ring");

    a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_word.mode == MODE_TOGGLE |=> r_flag != $past(r_flag))
        else $error("toggle did not flip order");

    a_access_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_op.wr && w_op.rd))
        else $error("write and read in one op");

endmodule

/* hdl/rdb_queue.sv */
// two entry queue between front and back
`timescale 1ns / 1ps

module rdb_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0] r_buf [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_buf[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == 2'd2))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

/* hdl/rdb_back.sv */
// back end: memory access and result register
`timescale 1ns / 1ps

module rdb_back import rdb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_op                      i_op,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic                     o_strobe,
    output t_out_word                o_word
);

    logic       r_valid;
    t_op        r_op;
    logic [7:0] w_rdata;

    rdb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_valid && i_op.wr),
        .i_addr  (i_addr),
        .i_wdata (i_op.data),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_op <= i_op;
        end
    end

    assign o_strobe        = r_valid;
    assign o_word.status   = r_op.status;
    assign o_word.char_out = r_op.rd ? w_rdata : 8'd0;
    assign o_word.last     = r_op.last;
    assign o_word.fill     = r_op.fill;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> o_strobe)
        else $error("op issued without result");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_word.last |-> o_word.status == ST_OK && o_word.fill == '0)
        else $error("last flag on bad result");

    a_full_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_word.status != ST_OK |-> o_word.char_out == 8'd0)
        else $error("data on failed op");

endmodule

/* hdl/reversible_deque_buffer.sv */
// top level of the reversible byte deque
`timescale 1ns / 1ps

// an accepted word enters the two entry queue; the back end then registers its op, read data and strobe
// throughput: one word per cycle; the back end drains one op per cycle from the queue
// busy rises only if the two entry queue fills, which cannot happen while the back drains
// reset (synchronous, active low) empties the deque, clears head and order flag
// the byte store itself is not cleared; only held bytes are ever read
// results cannot be stalled by the receiver
module reversible_deque_buffer import rdb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(t_op) + AW;

    // front side handshake
    logic          w_accept;
    logic          w_push;
    t_op           w_front_op;
    logic [AW-1:0] w_front_addr;

    // queue side
    logic [QW-1:0] w_q_in;
    logic [QW-1:0] w_q_out;
    logic          w_q_empty;
    logic          w_q_full;
    logic          w_pop;

    // back side
    t_op           w_back_op;
    logic [AW-1:0] w_back_addr;

    assign w_accept = start && !busy;
    assign busy     = w_q_full;

    // front updates head, count and order flag as each word is taken
    rdb_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_word),
        .o_push   (w_push),
        .o_op     (w_front_op),
        .o_addr   (w_front_addr)
    );

    // op and slot address ride the queue together
    assign w_q_in = {w_front_op, w_front_addr};

    rdb_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // back always drains: the receiver never holds results off
    assign w_pop       = !w_q_empty;
    assign w_back_op   = w_q_out[QW-1:AW];
    assign w_back_addr = w_q_out[AW-1:0];

    rdb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pop),
        .i_op     (w_back_op),
        .i_addr   (w_back_addr),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

endmodule
